// File: sv/crlf_pkg.sv
// Shared types, constants and helpers for the CR LF line receiver.
// Used by the front end, command queue, back end and top level; depends on nothing.
`default_nettype none
package crlf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  // count may reach STORE_DEPTH itself when a fixed frame ends on the last entry
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PW     = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;

  localparam logic [1:0] ACT_RECV    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic       line_done;
    logic       cr_pending;
    logic [7:0] line_length;
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
    status_t          status;
  } cmd_t;

  function automatic logic [CMP_W-1:0] cnt_ext(input logic [CNT_W-1:0] cnt);
    return CMP_W'(cnt);
  endfunction

  function automatic logic [7:0] cnt_low8(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] t;
    t = CMP_W'(cnt);
    return t[7:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/crlf_front.sv
// Front end: accepts items, keeps line state and the frame length register,
// and issues store commands with status. Depends on crlf_pkg.
`default_nettype none
module crlf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_rx_byte,
  input  logic [7:0]          in_read_index,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output crlf_pkg::cmd_t      q_cmd
);
  import crlf_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cr_r, cr_nxt;
  logic             done_r, done_nxt;
  logic [7:0]       ffl_r;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    cnt_nxt  = cnt_r;
    cr_nxt   = cr_r;
    done_nxt = done_r;
    q_cmd.op   = OP_NONE;
    q_cmd.addr = cnt_r[IDX_W-1:0];
    q_cmd.data = in_rx_byte;
    case (in_action)
      ACT_RECV: begin
        if (done_r) begin
          // hold: finished line waits for release
        end else if (cr_r) begin
          if (in_rx_byte != BYTE_LF) begin
            cnt_nxt = '0;
            cr_nxt  = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end else if (in_rx_byte == BYTE_CR) begin
          cr_nxt = 1'b1;
        end else begin
          q_cmd.op = OP_WRITE;
          if (ffl_r != 8'd0 && cnt_ext(cnt_inc) >= CMP_W'(ffl_r)) begin
            done_nxt = 1'b1;
            cnt_nxt  = cnt_inc;
          end else if (cnt_inc == CNT_W'(STORE_DEPTH)) begin
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ACT_READ: begin
        q_cmd.op   = OP_READ;
        q_cmd.addr = IDX_W'(in_read_index);
      end
      ACT_RELEASE: begin
        cnt_nxt  = '0;
        cr_nxt   = 1'b0;
        done_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    q_cmd.status.line_done   = done_nxt;
    q_cmd.status.cr_pending  = cr_nxt;
    q_cmd.status.line_length = cnt_low8(cnt_nxt);
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cr_r   <= 1'b0;
      done_r <= 1'b0;
      ffl_r  <= 8'd0;
    end else begin
      if (accept) begin
        cnt_r  <= cnt_nxt;
        cr_r   <= cr_nxt;
        done_r <= done_nxt;
      end
      if (cfg_valid) begin
        ffl_r <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/crlf_cmdq.sv
// Short command queue between front and back ends.
// Depends on crlf_pkg for the command type and depth.
`default_nettype none
module crlf_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crlf_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output crlf_pkg::cmd_t  head
);
  import crlf_pkg::*;

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wp_r, rp_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/crlf_back.sv
// Back end: owns the line store, carries out writes and reads in order,
// and holds the result register. Depends on crlf_pkg.
`default_nettype none
module crlf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  crlf_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic            out_line_done,
  output logic            out_cr_pending,
  output logic [7:0]      out_line_length,
  output logic [7:0]      out_read_data
);
  import crlf_pkg::*;

  logic [7:0] store_r [STORE_DEPTH];
  logic       res_valid_r;
  status_t    res_status_r;
  logic [7:0] rdata_r;
  logic       take;

  // advance when the result slot is free or drains this cycle
  assign take    = cmd_valid && (!res_valid_r || out_pop);
  assign cmd_pop = take;

  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.op == OP_WRITE) begin
        store_r[cmd.addr] <= cmd.data;
      end
      if (cmd.op == OP_READ) begin
        rdata_r <= store_r[cmd.addr];
      end else begin
        rdata_r <= 8'd0;
      end
      res_status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (out_pop) begin
      res_valid_r <= 1'b0;
    end
  end

  assign out_empty       = !res_valid_r;
  assign out_line_done   = res_status_r.line_done;
  assign out_cr_pending  = res_status_r.cr_pending;
  assign out_line_length = res_status_r.line_length;
  assign out_read_data   = rdata_r;

endmodule
`default_nettype wire

// File: sv/crlf_line_receiver_top.sv
// CR LF line receiver: one item per clock cycle while results are popped; each
// beat is registered in the command queue, then the result register. The front
// end updates line state per item and queues store commands; the back end does
// one store write or registered store read per cycle while its result slot is
// free or popped, so the single store port sets the rate. Bytes collect until CR
// LF or the fixed frame length; a held line ignores bytes until released. The
// user must write fixed_frame_len on the cfg channel only while no items are in
// flight; the block does not enforce it. Depends on crlf_pkg and three submodules.
`default_nettype none
module crlf_line_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_action,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_line_done,
  output logic       out_cr_pending,
  output logic [7:0] out_line_length,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import crlf_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_cmd, q_head;

  crlf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_rx_byte    (in_rx_byte),
    .in_read_index (in_read_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  crlf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  crlf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (q_head),
    .cmd_pop         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_line_done   (out_line_done),
    .out_cr_pending  (out_cr_pending),
    .out_line_length (out_line_length),
    .out_read_data   (out_read_data)
  );

endmodule
`default_nettype wire

// File: sv/crlf_checker.sv
// Port-level checks for the CR LF line receiver, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module crlf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_line_done,
  input logic       out_cr_pending,
  input logic [7:0] out_line_length,
  input logic [7:0] out_read_data
);

  // reset drains both queues
  a_reset_drains: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a full command queue means the result slot is occupied
  a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("command queue full with no result waiting");

  // a result waiting for pop stays put
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_line_done)
      && $stable(out_cr_pending) && $stable(out_line_length)
      && $stable(out_read_data)))
    else $error("waiting result changed");

endmodule

bind crlf_line_receiver_top crlf_checker u_crlf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_line_done   (out_line_done),
  .out_cr_pending  (out_cr_pending),
  .out_line_length (out_line_length),
  .out_read_data   (out_read_data)
);
`default_nettype wire
